// ===== sv/hrt_pkg.sv =====
// Package for the HTTP request tokenizer: phases, field codes, result type.
package hrt_pkg;

  typedef enum logic [3:0] {
    PH_METHOD    = 4'd0,
    PH_PRE_PATH  = 4'd1,
    PH_PATH      = 4'd2,
    PH_PRE_PROTO = 4'd3,
    PH_PROTO     = 4'd4,
    PH_GAP       = 4'd5,
    PH_NAME      = 4'd6,
    PH_SEP       = 4'd7,
    PH_VALUE     = 4'd8,
    PH_DONE      = 4'd9
  } phase_t;

  localparam logic [2:0] KIND_SKIP  = 3'd0;
  localparam logic [2:0] KIND_METHOD = 3'd1;
  localparam logic [2:0] KIND_PATH  = 3'd2;
  localparam logic [2:0] KIND_PROTO = 3'd3;
  localparam logic [2:0] KIND_NAME  = 3'd4;
  localparam logic [2:0] KIND_VALUE = 3'd5;

  localparam logic [1:0] STATUS_BUSY    = 2'd0;
  localparam logic [1:0] STATUS_OK      = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  localparam logic [3:0] MIN_LENGTH = 4'd15;
  localparam logic [3:0] POS_MAX    = 4'd15;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;

  // match bit 0: "GET ", bit 1: "POST"
  localparam logic [1:0] MATCH_BOTH = 2'b11;
  localparam logic [1:0] MATCH_GET  = 2'b01;
  localparam logic [1:0] MATCH_POST = 2'b10;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] field_kind;
    logic       field_first;
    logic [1:0] status;
  } token_t;

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0: c = 8'h47;    // G
      2'd1: c = 8'h45;    // E
      2'd2: c = 8'h54;    // T
      default: c = 8'h20; // space
    endcase
    return c;
  endfunction

  function automatic logic [7:0] post_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0: c = 8'h50;    // P
      2'd1: c = 8'h4f;    // O
      2'd2: c = 8'h53;    // S
      default: c = 8'h54; // T
    endcase
    return c;
  endfunction

endpackage

// ===== sv/hrt_if.sv =====
// Stream interfaces for request bytes in and tagged tokens out.
interface byte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface token_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] field_kind;
  logic       field_first;
  logic [1:0] status;

  modport source (output valid, output out_byte, output field_kind,
                  output field_first, output status, input ready);
  modport sink   (input valid, input out_byte, input field_kind,
                  input field_first, input status, output ready);
endinterface

// ===== sv/http_request_tokenizer_top.sv =====
// Top level of the HTTP request line and header tokenizer.
//
//   port   dir   content
//   req    in    in_byte[7:0], last_byte
//   tok    out   out_byte[7:0], field_kind[2:0], field_first, status[1:0]
//
// One byte per cycle while req.ready is high; each tagged byte is registered
// in the output buffer. Parser state updates on each transfer, so bytes
// stream back to back. A two-entry output buffer lets one more byte enter
// while tok is stalled; req.ready drops only when both entries are full.
// Synchronous reset returns the parser to the method phase and empties the buffer.
// Parser state also restarts after each byte marked last_byte.
module http_request_tokenizer_top
  import hrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  byte_in_if.sink     req,
  token_out_if.source tok
);

  logic   res_valid;
  logic   res_ready;
  token_t res;

  hrt_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  hrt_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .push_ready (res_ready),
    .tok        (tok)
  );

  a_first_has_kind: assert property (@(posedge clk) disable iff (rst)
    tok.valid && tok.field_first |-> tok.field_kind != KIND_SKIP)
    else $error("field_first set on a skipped byte");

  a_result_next_cycle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && !tok.valid |=> tok.valid)
    else $error("transfer into empty buffer produced no result");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    tok.valid |-> tok.field_kind <= KIND_VALUE && tok.status != 2'd3)
    else $error("token code out of range");

endmodule

// ===== sv/hrt_parser.sv =====
// Parser state and per-byte tagging logic.
module hrt_parser
  import hrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  byte_in_if.sink     req,
  input  logic        res_ready,
  output logic        res_valid,
  output token_t      res
);

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] byte_position;
  logic [1:0] method_match;
  logic [1:0] method_match_next;
  logic [1:0] newline_count;
  logic [1:0] newline_count_next;
  logic       invalid_flag;
  logic       invalid_flag_next;

  logic       fire;
  logic [7:0] b;
  logic [1:0] nl_inc;
  logic [1:0] mm;
  logic [2:0] kind;
  logic       first;
  logic       ok;

  assign req.ready = res_ready;
  assign fire      = req.valid && res_ready;
  assign res_valid = fire;
  assign b         = req.in_byte;
  assign nl_inc    = (newline_count == 2'd3) ? 2'd3 : newline_count + 2'd1;

  always_comb begin
    mm = method_match;
    if (b != get_char(byte_position[1:0])) mm = mm & MATCH_POST;
    if (b != post_char(byte_position[1:0])) mm = mm & MATCH_GET;
  end

  // next state
  always_comb begin
    phase_next         = phase;
    method_match_next  = method_match;
    newline_count_next = newline_count;
    invalid_flag_next  = invalid_flag;
    if (!invalid_flag) begin
      case (phase)
        PH_METHOD: begin
          method_match_next = mm;
          if (byte_position >= 4'd3) begin
            if (mm == 2'b00) begin
              invalid_flag_next = 1'b1;
              phase_next        = PH_DONE;
            end else begin
              phase_next = PH_PRE_PATH;
            end
          end
        end
        PH_PRE_PATH: begin
          if (b != CH_SPACE) phase_next = PH_PATH;
        end
        PH_PATH: begin
          if (b == CH_SPACE) phase_next = PH_PRE_PROTO;
        end
        PH_PRE_PROTO: begin
          if (b == CH_LF) begin
            invalid_flag_next = 1'b1;
            phase_next        = PH_DONE;
          end else if (b != CH_SPACE && b != CH_CR) begin
            phase_next = PH_PROTO;
          end
        end
        PH_PROTO: begin
          if (b == CH_LF) begin
            phase_next         = PH_GAP;
            newline_count_next = 2'd1;
          end
        end
        PH_GAP: begin
          if (b == CH_LF) begin
            newline_count_next = nl_inc;
            if (nl_inc >= 2'd2) phase_next = PH_DONE;
          end else if (b == CH_COLON) begin
            phase_next = PH_DONE;
          end else if (b != CH_SPACE && b != CH_CR) begin
            phase_next         = PH_NAME;
            newline_count_next = 2'd0;
          end
        end
        PH_NAME, PH_SEP, PH_VALUE: begin
          // a space ends a value; in a name it or a colon opens the separator
          if (b == CH_CR || b == CH_LF || (phase == PH_VALUE && b == CH_SPACE)) begin
            phase_next         = PH_GAP;
            newline_count_next = (b == CH_LF) ? 2'd1 : 2'd0;
          end else if (phase == PH_NAME && (b == CH_SPACE || b == CH_COLON)) begin
            phase_next = PH_SEP;
          end else if (phase == PH_SEP && b != CH_SPACE && b != CH_COLON) begin
            phase_next = PH_VALUE;
          end
        end
        default: ;
      endcase
    end
  end

  // outputs
  always_comb begin
    kind  = KIND_SKIP;
    first = 1'b0;
    if (!invalid_flag) begin
      case (phase)
        PH_METHOD: begin
          kind  = KIND_METHOD;
          first = (byte_position == 4'd0);
        end
        PH_PRE_PATH: begin
          if (b != CH_SPACE) begin
            kind  = KIND_PATH;
            first = 1'b1;
          end
        end
        PH_PATH: begin
          if (b != CH_SPACE) kind = KIND_PATH;
        end
        PH_PRE_PROTO: begin
          if (b != CH_SPACE && b != CH_CR && b != CH_LF) begin
            kind  = KIND_PROTO;
            first = 1'b1;
          end
        end
        PH_PROTO: begin
          if (b != CH_LF && b != CH_CR) kind = KIND_PROTO;
        end
        PH_GAP: begin
          if (b != CH_SPACE && b != CH_CR && b != CH_LF && b != CH_COLON) begin
            kind  = KIND_NAME;
            first = 1'b1;
          end
        end
        PH_NAME: begin
          if (b != CH_SPACE && b != CH_COLON && b != CH_CR && b != CH_LF) kind = KIND_NAME;
        end
        PH_SEP: begin
          if (b != CH_SPACE && b != CH_COLON && b != CH_CR && b != CH_LF) begin
            kind  = KIND_VALUE;
            first = 1'b1;
          end
        end
        PH_VALUE: begin
          if (b != CH_SPACE && b != CH_CR && b != CH_LF) kind = KIND_VALUE;
        end
        default: ;
      endcase
    end
    ok = !invalid_flag_next && (byte_position >= MIN_LENGTH - 4'd1) &&
         (phase_next inside {[PH_PROTO:PH_DONE]});
    res.out_byte    = b;
    res.field_kind  = kind;
    res.field_first = first;
    res.status      = !req.last_byte ? STATUS_BUSY : (ok ? STATUS_OK : STATUS_INVALID);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_METHOD;
      byte_position <= 4'd0;
      method_match  <= MATCH_BOTH;
      newline_count <= 2'd0;
      invalid_flag  <= 1'b0;
    end else if (fire) begin
      if (req.last_byte) begin
        phase         <= PH_METHOD;
        byte_position <= 4'd0;
        method_match  <= MATCH_BOTH;
        newline_count <= 2'd0;
        invalid_flag  <= 1'b0;
      end else begin
        phase         <= phase_next;
        byte_position <= (byte_position == POS_MAX) ? POS_MAX : byte_position + 4'd1;
        method_match  <= method_match_next;
        newline_count <= newline_count_next;
        invalid_flag  <= invalid_flag_next;
      end
    end
  end

endmodule

// ===== sv/hrt_out_buf.sv =====
// Result register with a skid entry so one more input byte can enter during a stall.
module hrt_out_buf
  import hrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  token_t      push_data,
  output logic        push_ready,
  token_out_if.source tok
);

  logic   main_valid;
  token_t main_data;
  logic   skid_valid;
  token_t skid_data;
  logic   pop;

  assign push_ready      = !skid_valid;
  assign pop             = main_valid && tok.ready;
  assign tok.valid       = main_valid;
  assign tok.out_byte    = main_data.out_byte;
  assign tok.field_kind  = main_data.field_kind;
  assign tok.field_first = main_data.field_first;
  assign tok.status      = main_data.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

endmodule

// ===== sim/http_request_tokenizer_top_test.sv =====
// Self-checking testbench for the HTTP request tokenizer top level.
module http_request_tokenizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hrt_pkg::*;

  typedef logic [7:0] byte_q [$];

  localparam logic [7:0] GET_TEXT  [4] = '{"G", "E", "T", " "};
  localparam logic [7:0] POST_TEXT [4] = '{"P", "O", "S", "T"};
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BYTES_PER_PASS = 256;

  // Tracks the parser state and keeps the tagged bytes still owed by the block.
  class request_tagger;
    token_t     expected_tokens[$];
    phase_t     phase;
    logic [3:0] position;
    logic [1:0] candidates;
    logic [1:0] newlines;
    bit         invalid;
    int         errors;
    int         accepted_reqs;
    int         invalid_reqs;

    function new();
      restart();
    endfunction

    function void restart();
      phase      = PH_METHOD;
      position   = '0;
      candidates = MATCH_BOTH;
      newlines   = '0;
      invalid    = 1'b0;
    endfunction

    function void end_line(logic [7:0] b);
      phase    = PH_GAP;
      newlines = (b == CH_LF) ? 2'd1 : 2'd0;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      token_t     t;
      logic [3:0] pos;
      bit         ok;
      t.out_byte    = b;
      t.field_kind  = KIND_SKIP;
      t.field_first = 1'b0;
      t.status      = STATUS_BUSY;
      pos = position;
      if (!invalid) begin
        case (phase)
          PH_METHOD: begin
            t.field_kind  = KIND_METHOD;
            t.field_first = (pos == 0);
            if (b != GET_TEXT[pos[1:0]]) candidates &= MATCH_POST;
            if (b != POST_TEXT[pos[1:0]]) candidates &= MATCH_GET;
            if (pos >= 3) begin
              if (candidates == 2'b00) begin
                invalid = 1'b1;
                phase   = PH_DONE;
              end else begin
                phase = PH_PRE_PATH;
              end
            end
          end
          PH_PRE_PATH: begin
            if (b != CH_SPACE) begin
              t.field_kind  = KIND_PATH;
              t.field_first = 1'b1;
              phase         = PH_PATH;
            end
          end
          PH_PATH: begin
            if (b == CH_SPACE) phase = PH_PRE_PROTO;
            else t.field_kind = KIND_PATH;
          end
          PH_PRE_PROTO: begin
            if (b == CH_SPACE || b == CH_CR) begin
            end else if (b == CH_LF) begin
              invalid = 1'b1;
              phase   = PH_DONE;
            end else begin
              t.field_kind  = KIND_PROTO;
              t.field_first = 1'b1;
              phase         = PH_PROTO;
            end
          end
          PH_PROTO: begin
            if (b == CH_LF) begin
              phase    = PH_GAP;
              newlines = 2'd1;
            end else if (b != CH_CR) begin
              t.field_kind = KIND_PROTO;
            end
          end
          PH_GAP: begin
            if (b == CH_SPACE || b == CH_CR) begin
            end else if (b == CH_LF) begin
              if (newlines < 3) newlines++;
              if (newlines >= 2) phase = PH_DONE;
            end else if (b == CH_COLON) begin
              phase = PH_DONE;
            end else begin
              t.field_kind  = KIND_NAME;
              t.field_first = 1'b1;
              phase         = PH_NAME;
              newlines      = 2'd0;
            end
          end
          PH_NAME: begin
            if (b == CH_SPACE || b == CH_COLON) phase = PH_SEP;
            else if (b == CH_CR || b == CH_LF) end_line(b);
            else t.field_kind = KIND_NAME;
          end
          PH_SEP: begin
            if (b == CH_SPACE || b == CH_COLON) begin
            end else if (b == CH_CR || b == CH_LF) begin
              end_line(b);
            end else begin
              t.field_kind  = KIND_VALUE;
              t.field_first = 1'b1;
              phase         = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (b == CH_SPACE || b == CH_CR || b == CH_LF) end_line(b);
            else t.field_kind = KIND_VALUE;
          end
          default: begin
          end
        endcase
      end
      if (position < POS_MAX) position++;
      if (last) begin
        ok = !invalid && (int'(pos) + 1 >= int'(MIN_LENGTH)) &&
             phase >= PH_PROTO && phase <= PH_DONE;
        t.status = ok ? STATUS_OK : STATUS_INVALID;
        if (ok) accepted_reqs++;
        else invalid_reqs++;
        restart();
      end
      expected_tokens.push_back(t);
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (expected_tokens.size() == 0) begin
        $error("token with no byte pending: out_byte %0d", got.out_byte);
        errors++;
        return;
      end
      want = expected_tokens.pop_front();
      compare("out_byte", int'(want.out_byte), int'(got.out_byte));
      compare("field_kind", int'(want.field_kind), int'(got.field_kind));
      compare("field_first", int'(want.field_first), int'(got.field_first));
      compare("status", int'(want.status), int'(got.status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  byte_in_if   req();
  token_out_if tok();

  http_request_tokenizer_top dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .tok(tok)
  );

  request_tagger tagger = new();

  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_asked = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int sent       = 0;
  int buffers    = 0;

  always #6 clk = ~clk;

  // Sink side: random stalls, plus long hold-offs on request.
  always @(posedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      tok.ready <= 1'b0;
    end else begin
      tok.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && tok.valid && tok.ready)
      tagger.check_token({tok.out_byte, tok.field_kind, tok.field_first, tok.status});
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (tok.valid && tok.ready)) quiet = 0;
      else quiet++;
    end
    $display("http_request_tokenizer_top: mismatch");
    $finish;
  end

  function automatic logic [7:0] word_char();
    return 8'($urandom_range(8'h21, 8'h7e));
  endfunction

  function automatic void line_end(ref byte_q q);
    if ($urandom_range(1)) q.push_back(CH_CR);
    q.push_back(CH_LF);
  endfunction

  // Mostly well-formed requests with random content; some noise and truncation.
  function automatic byte_q make_request();
    byte_q      q;
    int         n;
    int         bad;
    bit         post;
    logic [7:0] c;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 20);
      repeat (n) q.push_back(8'($urandom_range(255)));
      return q;
    end
    post = 1'($urandom_range(1));
    bad  = ($urandom_range(14) == 0) ? $urandom_range(3) : -1;
    for (int i = 0; i < 4; i++) begin
      c = post ? POST_TEXT[i] : GET_TEXT[i];
      if (i == bad) c = 8'($urandom_range(255));
      q.push_back(c);
    end
    repeat ($urandom_range(2)) q.push_back(CH_SPACE);
    n = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
    repeat (n) q.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : word_char());
    repeat ($urandom_range(1, 2)) q.push_back(CH_SPACE);
    if ($urandom_range(5) == 0) q.push_back(CH_CR);
    n = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8);
    repeat (n) q.push_back(word_char());
    line_end(q);
    repeat ($urandom_range(3)) begin
      repeat ($urandom_range(1, 6)) q.push_back(word_char());
      if ($urandom_range(9) == 0) q.push_back($urandom_range(1) ? CH_CR : CH_LF);
      q.push_back(CH_COLON);
      repeat ($urandom_range(2)) q.push_back(CH_SPACE);
      repeat ($urandom_range(6)) begin
        q.push_back(word_char());
        if ($urandom_range(9) == 0) q.push_back(CH_SPACE);
      end
      line_end(q);
    end
    case ($urandom_range(3))
      0, 1: line_end(q);
      2: q.push_back(CH_COLON);
      default: begin
      end
    endcase
    repeat ($urandom_range(4)) q.push_back(8'($urandom_range(255)));
    if ($urandom_range(7) == 0) begin
      n = $urandom_range(1, q.size());
      while (q.size() > n) void'(q.pop_back());
    end
    return q;
  endfunction

  // valid stays high across back-to-back transfers; it drops only on an idle cycle
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.in_byte   <= b;
    req.last_byte <= last;
    do @(posedge clk); while (!req.ready);
    tagger.take_byte(b, last);
    sent++;
  endtask

  task automatic send_buffer(input byte_q q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    buffers++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (tagger.expected_tokens.size() != 0);
  endtask

  initial begin : stimulus
    byte_q text;
    int    target;
    req.valid     = 1'b0;
    req.in_byte   = '0;
    req.last_byte = 1'b0;
    tok.ready     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // method mismatch with extreme byte values
    text = '{8'h00, 8'hff};
    send_buffer(text);
    // newline right after the method, tagged as path along with the later byte
    text = '{"P", "O", "S", "T", CH_LF, "z"};
    send_buffer(text);
    // newline in path, CR before and inside protocol, name cut by CR,
    // space ending a value, double newline, trailing byte after headers
    text = '{"G", "E", "T", " ", "a", CH_LF, " ", CH_CR, "P", CH_CR, CH_LF,
             "N", CH_CR, "V", ":", " ", "v", " ", "w", CH_CR, CH_LF, CH_LF, "x"};
    send_buffer(text);
    drain();

    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          idle_pct  = 6;
          stall_pct = 51;
        end
        1: begin
          idle_pct  = 51;
          stall_pct = 6;
        end
        default: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
      endcase
      if (pass != 1) hold_asked++;
      target = sent + BYTES_PER_PASS;
      while (sent < target) send_buffer(make_request());
      drain();
    end

    repeat (4) @(posedge clk);
    if (tagger.expected_tokens.size() != 0) begin
      $error("%0d tagged bytes never came out", tagger.expected_tokens.size());
      tagger.errors++;
    end
    $display("Streamed %0d bytes in %0d buffers: %0d requests accepted, %0d invalid.",
             sent, buffers, tagger.accepted_reqs, tagger.invalid_reqs);
    $display("Passes ran with sender gaps, receiver stalls, long output hold-offs.");
    if (tagger.errors == 0) begin
      $display("http_request_tokenizer_top: match");
    end else begin
      $display("http_request_tokenizer_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== http_request_tokenizer_top.f =====
sv/hrt_pkg.sv
sv/hrt_if.sv
sv/hrt_parser.sv
sv/hrt_out_buf.sv
sv/http_request_tokenizer_top.sv
sim/http_request_tokenizer_top_test.sv
